// ----- hw/rtl/hcbp_pkg.sv -----
// Shared types and constants for the Huffman code bit packer.
// No dependencies; imported by the top level and by hcbp_front, hcbp_fifo and hcbp_back.
package hcbp_pkg;

	localparam int BYTE_W   = 8;
	localparam int SYM_W    = 8;
	localparam int CODE_W   = 32;
	localparam int LEN_W    = 6;
	localparam int CMD_W    = 2;
	localparam int NUM_SYMS = 256;
	localparam int ENTRY_W  = CODE_W + LEN_W;
	// pending byte plus a code shifted by up to seven places
	localparam int ACC_W    = CODE_W + BYTE_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_FLUSH  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		OP_ENCODE = 2'd0,
		OP_ABSENT = 2'd1,
		OP_FLUSH  = 2'd2
	} op_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_EMIT = 1'b1
	} bk_state_t;

	// work item handed from front to back
	typedef struct packed {
		op_t               op;
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] bits;
	} work_t;

endpackage

// ----- hw/rtl/huffman_code_bit_packer.sv -----
// Huffman code bit packer. Encodes and flushes go through lookup, queue and output register.
// Throughput: one item per cycle unless the queue fills; an encode completing k bytes (k >= 2)
// holds the back end as they leave the packing register one per cycle; output stalls back up.
// Reset (arst_n, async low) clears pending bits, queue, output register and code table marks;
// the table is usable in the first cycle after reset, no clearing pass.
// Depends on hcbp_pkg, hcbp_front, hcbp_fifo, hcbp_back.
module huffman_code_bit_packer #(
	parameter int MAX_CODE_LEN = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [hcbp_pkg::CMD_W-1:0]  cmd,
	input  logic [hcbp_pkg::SYM_W-1:0]  symbol,
	input  logic [hcbp_pkg::CODE_W-1:0] code_bits,
	input  logic [hcbp_pkg::LEN_W-1:0]  code_length,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [hcbp_pkg::BYTE_W-1:0] out_byte,
	output logic                        error,
	output logic                        last
);
	import hcbp_pkg::*;

	// Front: loads go straight into the table (marked written), encodes read
	// it; in the next cycle the looked-up entry is classified into a work item.
	// Items that cause no result (loads, unused commands) end in the front.
	logic  push, q_full, pop, q_valid;
	work_t push_item, q_head;

	hcbp_front #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.symbol      (symbol),
		.code_bits   (code_bits),
		.code_length (code_length),
		.push        (push),
		.push_item   (push_item),
		.q_full      (q_full)
	);

	// Two-entry queue lets the front keep taking items while the back
	// drains a multi-byte code or waits on the output.
	hcbp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	// Back: owns the pending byte, packs LSB first, emits one byte per cycle while the output is not stalled.
	hcbp_back #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.error     (error),
		.last      (last)
	);
endmodule

// ----- hw/rtl/hcbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hcbp_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- hw/rtl/hcbp_front.sv -----
// Front end: accepts items, writes code table loads, looks up encodes.
// Depends on hcbp_pkg and hcbp_ram.
module hcbp_front #(
	parameter int MAX_CODE_LEN = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [hcbp_pkg::CMD_W-1:0]  cmd,
	input  logic [hcbp_pkg::SYM_W-1:0]  symbol,
	input  logic [hcbp_pkg::CODE_W-1:0] code_bits,
	input  logic [hcbp_pkg::LEN_W-1:0]  code_length,
	output logic                        push,
	output hcbp_pkg::work_t             push_item,
	input  logic                        q_full
);
	import hcbp_pkg::*;

	logic               acc;
	logic               is_load, is_enc, is_flush;
	logic [LEN_W-1:0]   len_sat;
	logic [CODE_W-1:0]  mask;
	logic [ENTRY_W-1:0] wdata, rdata;
	logic [NUM_SYMS-1:0] valid_q;
	logic               v_s1, flush_s1, hit_s1;

	assign in_ready = !v_s1 || !q_full;
	assign acc      = in_valid && in_ready;
	assign is_load  = (cmd == CMD_LOAD);
	assign is_enc   = (cmd == CMD_ENCODE);
	assign is_flush = (cmd == CMD_FLUSH);

	// saturate length, clear code bits at or above it
	always_comb begin
		if (code_length > LEN_W'(MAX_CODE_LEN)) begin
			len_sat = LEN_W'(MAX_CODE_LEN);
		end else begin
			len_sat = code_length;
		end
		for (int i = 0; i < CODE_W; i++) begin
			mask[i] = (i < int'(len_sat));
		end
	end
	assign wdata = {len_sat, code_bits & mask};

	hcbp_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_SYMS)) u_table (
		.clk   (clk),
		.we    (acc && is_load),
		.waddr (symbol),
		.wdata (wdata),
		.re    (acc && is_enc),
		.raddr (symbol),
		.rdata (rdata)
	);

	// written marks stand in for clearing the table at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (acc && is_load) begin
			valid_q[symbol] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= acc && (is_enc || is_flush);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			flush_s1 <= is_flush;
			hit_s1   <= valid_q[symbol];
		end
	end

	assign push = v_s1 && !q_full;

	always_comb begin
		push_item.len  = rdata[ENTRY_W-1:CODE_W];
		push_item.bits = rdata[CODE_W-1:0];
		if (flush_s1) begin
			push_item.op = OP_FLUSH;
		end else if (!hit_s1 || push_item.len == '0) begin
			push_item.op = OP_ABSENT;
		end else begin
			push_item.op = OP_ENCODE;
		end
	end
endmodule

// ----- hw/rtl/hcbp_fifo.sv -----
// Two-entry queue between front and back.
// Depends on hcbp_pkg.
module hcbp_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hcbp_pkg::work_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output hcbp_pkg::work_t head
);
	import hcbp_pkg::*;

	work_t      slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule

// ----- hw/rtl/hcbp_back.sv -----
// Back end: packs code bits into bytes and drives the output register.
// Depends on hcbp_pkg.
module hcbp_back #(
	parameter int MAX_CODE_LEN = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  hcbp_pkg::work_t             q_head,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [hcbp_pkg::BYTE_W-1:0] out_byte,
	output logic                        error,
	output logic                        last
);
	import hcbp_pkg::*;

	localparam int TOT_W = $clog2(MAX_CODE_LEN + 16);
	localparam logic [TOT_W-1:0] ONE_B = TOT_W'(8);
	localparam logic [TOT_W-1:0] TWO_B = TOT_W'(16);

	bk_state_t         state_q, state_d;
	logic [ACC_W-1:0]  acc_q, acc_d, a;
	logic [TOT_W-1:0]  tot_q, tot_d, t;
	logic [BYTE_W-1:0] pb_q, pb_d, ob_q, ob_d;
	logic [2:0]        pc_q, pc_d;
	logic              ov_q, ov_d, er_q, er_d, la_q, la_d;
	logic              out_free;

	assign out_free = !ov_q || out_ready;
	assign pop      = (state_q == BK_IDLE) && q_valid && out_free;
	assign a        = ACC_W'(pb_q) | (ACC_W'(q_head.bits) << pc_q);
	assign t        = TOT_W'(pc_q) + TOT_W'(q_head.len);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (pop && q_head.op == OP_ENCODE && t >= TWO_B) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (out_free && tot_q < TWO_B) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		acc_d = acc_q;
		tot_d = tot_q;
		pb_d  = pb_q;
		pc_d  = pc_q;
		ov_d  = ov_q && !out_ready;
		ob_d  = ob_q;
		er_d  = er_q;
		la_d  = la_q;
		case (state_q)
			BK_IDLE: begin
				if (pop) begin
					case (q_head.op)
						OP_FLUSH: begin
							ov_d = 1'b1;
							ob_d = pb_q;
							er_d = 1'b0;
							la_d = 1'b1;
							pb_d = '0;
							pc_d = '0;
						end
						OP_ABSENT: begin
							ov_d = 1'b1;
							ob_d = '0;
							er_d = 1'b1;
							la_d = 1'b1;
						end
						OP_ENCODE: begin
							if (t >= ONE_B) begin
								ov_d  = 1'b1;
								ob_d  = a[BYTE_W-1:0];
								er_d  = 1'b0;
								la_d  = (t < TWO_B);
								acc_d = a >> BYTE_W;
								tot_d = t - ONE_B;
								if (t < TWO_B) begin
									pb_d = a[2*BYTE_W-1:BYTE_W];
									pc_d = t[2:0];
								end
							end else begin
								pb_d = a[BYTE_W-1:0];
								pc_d = t[2:0];
							end
						end
						default: ;
					endcase
				end
			end
			BK_EMIT: begin
				if (out_free) begin
					ov_d  = 1'b1;
					ob_d  = acc_q[BYTE_W-1:0];
					er_d  = 1'b0;
					la_d  = (tot_q < TWO_B);
					acc_d = acc_q >> BYTE_W;
					tot_d = tot_q - ONE_B;
					if (tot_q < TWO_B) begin
						pb_d = acc_q[2*BYTE_W-1:BYTE_W];
						pc_d = tot_q[2:0];
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			ov_q    <= 1'b0;
			pb_q    <= '0;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			ov_q    <= ov_d;
			pb_q    <= pb_d;
			pc_q    <= pc_d;
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_d;
		tot_q <= tot_d;
		ob_q  <= ob_d;
		er_q  <= er_d;
		la_q  <= la_d;
	end

	assign out_valid = ov_q;
	assign out_byte  = ob_q;
	assign error     = er_q;
	assign last      = la_q;
endmodule

// ----- hw/rtl/hcbp_checker.sv -----
// Port-level checks for the Huffman code bit packer, bound to the top level.
// Depends on huffman_code_bit_packer.
module hcbp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       error,
	input logic       last
);
	// a waiting result holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(error)
			&& $stable(last))
		else $error("output changed while stalled");

	// a missing code gives a single zero byte
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> last && out_byte == 8'd0)
		else $error("bad error result");

	// bytes of one item come out back to back
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && !error)
		else $error("gap inside multi-byte item");

	// nothing is shown in the cycle right after reset is released
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("output valid right after reset");
endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (.*);
